@@ hw/rtl/ptq_pkg.sv @@
// ptq_pkg: shared types, codes and helpers of the periodic timer queue
// used by ptq_mem, ptq_seq and periodic_timer_queue_core
`default_nettype none
package ptq_pkg;

  localparam int unsigned DEF_NUM_TIMERS = 16;
  localparam int unsigned DEF_ID_BITS    = 16;
  localparam int unsigned DEF_OWNER_BITS = 8;

  localparam int unsigned TW       = 48;
  localparam int unsigned PER_W    = 35;
  localparam int unsigned IVL_W    = 24;
  localparam int unsigned FCNT_W   = 5;
  localparam int unsigned MS_TO_US = 1000;

  localparam logic [TW-1:0]     T_MAX    = {TW{1'b1}};
  localparam logic [FCNT_W-1:0] FCNT_MAX = {FCNT_W{1'b1}};

  typedef enum logic [2:0] {
    REQ_REGISTER  = 3'd0,
    REQ_REMOVE_ID = 3'd1,
    REQ_REMOVE_OW = 3'd2,
    REQ_WAIT      = 3'd3,
    REQ_ACTIVATE  = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_RD,
    S_INS_CHK,
    S_RM_RD,
    S_RM_WR,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_OWN_RD,
    S_OWN_CHK,
    S_WAIT,
    S_EXP_RD,
    S_EXP_CHK,
    S_ACT_HEAD,
    S_ACT_CHK,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              fired;
    logic [FCNT_W-1:0] fired_count;
    logic              wait_valid;
    logic [TW-1:0]     wait_us;
    logic              last;
  } res_t;

  function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [TW-1:0] b);
    logic [TW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TW] ? T_MAX : s[TW-1:0];
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/periodic_timer_queue_core.sv @@
// periodic_timer_queue_core: top level, sequencer, entry store and output register
// depends on ptq_pkg, ptq_mem, ptq_seq
//
// usage: one request item on the in_ channel (valid/stall); each request gives one
// result item on the out_ channel, an activate gives one item per fired timer and
// a closing item with the fired count; out_last marks the final item of a request.
// one request is worked at a time; in_stall is high from acceptance until the
// final item of the request sits in the output register.
// the time per request grows with n, the number of entries in the table: register,
// remove and activate walk the entry store, one read at a time; remove by owner
// takes longest when every entry matches, and activate walks it again per fired timer.
// reset clears the entry count and the control state; the store needs no clearing.
// while out_stall is high a valid item in the output register holds and the sequencer waits to emit.
`default_nettype none
module periodic_timer_queue_core
  import ptq_pkg::*;
#(
  parameter int unsigned NUM_TIMERS = DEF_NUM_TIMERS,
  parameter int unsigned ID_BITS    = DEF_ID_BITS,
  parameter int unsigned OWNER_BITS = DEF_OWNER_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [2:0]            in_req_type,
  input  wire logic [ID_BITS-1:0]    in_timer_id,
  input  wire logic [OWNER_BITS-1:0] in_owner_tag,
  input  wire logic [IVL_W-1:0]      in_interval_ms,
  input  wire logic [TW-1:0]         in_now_us,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 out_status,
  output logic [ID_BITS-1:0]         out_fired_id,
  output logic                       out_fired,
  output logic [FCNT_W-1:0]          out_fired_count,
  output logic                       out_wait_valid,
  output logic [TW-1:0]              out_wait_us,
  output logic                       out_last
);

  localparam int unsigned AW = $clog2(NUM_TIMERS);
  localparam int unsigned EW = ID_BITS + OWNER_BITS + PER_W + TW;

  logic               emit_valid;
  res_t               emit_res;
  logic [ID_BITS-1:0] emit_id;
  logic               emit_ack;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [EW-1:0]      mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [EW-1:0]      mem_rdata;

  logic               ov_r;
  res_t               ores_r;
  logic [ID_BITS-1:0] oid_r;

  ptq_mem #(
    .DEPTH (NUM_TIMERS),
    .EW    (EW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ptq_seq #(
    .NUM_TIMERS (NUM_TIMERS),
    .ID_BITS    (ID_BITS),
    .OWNER_BITS (OWNER_BITS)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_timer_id    (in_timer_id),
    .in_owner_tag   (in_owner_tag),
    .in_interval_ms (in_interval_ms),
    .in_now_us      (in_now_us),
    .emit_valid     (emit_valid),
    .emit_res       (emit_res),
    .emit_id        (emit_id),
    .emit_ack       (emit_ack),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  assign emit_ack = emit_valid && (!ov_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (emit_ack) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
    if (emit_ack) begin
      ores_r <= emit_res;
      oid_r  <= emit_id;
    end
  end

  assign out_valid       = ov_r;
  assign out_status      = ores_r.status;
  assign out_fired_id    = oid_r;
  assign out_fired       = ores_r.fired;
  assign out_fired_count = ores_r.fired_count;
  assign out_wait_valid  = ores_r.wait_valid;
  assign out_wait_us     = ores_r.wait_us;
  assign out_last        = ores_r.last;

endmodule
`default_nettype wire

@@ hw/rtl/ptq_mem.sv @@
// ptq_mem: timer entry store, one write port, one read port, registered read data
// depends on ptq_pkg
`default_nettype none
module ptq_mem
  import ptq_pkg::*;
#(
  parameter int unsigned DEPTH = DEF_NUM_TIMERS,
  parameter int unsigned EW    = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [EW-1:0]            wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [EW-1:0]            rdata
);

  logic [EW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hw/rtl/ptq_seq.sv @@
// ptq_seq: request sequencer, walks the sorted entry store for insert, remove,
// wait and activation; depends on ptq_pkg, drives ptq_mem
`default_nettype none
module ptq_seq
  import ptq_pkg::*;
#(
  parameter int unsigned NUM_TIMERS = DEF_NUM_TIMERS,
  parameter int unsigned ID_BITS    = DEF_ID_BITS,
  parameter int unsigned OWNER_BITS = DEF_OWNER_BITS,
  localparam int unsigned AW = $clog2(NUM_TIMERS),
  localparam int unsigned EW = ID_BITS + OWNER_BITS + PER_W + TW
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [2:0]            in_req_type,
  input  wire logic [ID_BITS-1:0]    in_timer_id,
  input  wire logic [OWNER_BITS-1:0] in_owner_tag,
  input  wire logic [IVL_W-1:0]      in_interval_ms,
  input  wire logic [TW-1:0]         in_now_us,
  output logic                       emit_valid,
  output res_t                       emit_res,
  output logic [ID_BITS-1:0]         emit_id,
  input  wire logic                  emit_ack,
  output logic                       mem_we,
  output logic [AW-1:0]              mem_waddr,
  output logic [EW-1:0]              mem_wdata,
  output logic [AW-1:0]              mem_raddr,
  input  wire logic [EW-1:0]         mem_rdata
);

  localparam int unsigned CW = $clog2(NUM_TIMERS + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(NUM_TIMERS);

  state_t                state_r, state_nxt;
  logic [2:0]            req_r, req_nxt;
  logic [ID_BITS-1:0]    id_r, id_nxt;
  logic [OWNER_BITS-1:0] owner_r, owner_nxt;
  logic [PER_W-1:0]      period_r, period_nxt;
  logic [TW-1:0]         now_r, now_nxt;
  logic [TW-1:0]         dl_r, dl_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [CW-1:0]         exp_r, exp_nxt;
  logic [FCNT_W-1:0]     nact_r, nact_nxt;
  logic                  mv_r, mv_nxt;
  logic [AW-1:0]         mark_r, mark_nxt;
  logic [PER_W-1:0]      mper_r, mper_nxt;
  logic                  cur_r, cur_nxt;
  res_t                  em_r, em_nxt;
  logic                  emf_r, emf_nxt;

  logic [ID_BITS-1:0]    rd_id;
  logic [OWNER_BITS-1:0] rd_owner;
  logic [PER_W-1:0]      rd_per;
  logic [TW-1:0]         rd_dl;
  logic                  ins_done;
  logic                  rm_done;

  assign rd_dl    = mem_rdata[TW-1:0];
  assign rd_per   = mem_rdata[TW +: PER_W];
  assign rd_owner = mem_rdata[TW+PER_W +: OWNER_BITS];
  assign rd_id    = mem_rdata[TW+PER_W+OWNER_BITS +: ID_BITS];

  assign in_stall   = (state_r != S_IDLE);
  assign emit_valid = (state_r == S_EMIT);
  assign emit_res   = em_r;
  assign emit_id    = emf_r ? id_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      mv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      mv_r    <= mv_nxt;
    end
    req_r    <= req_nxt;
    id_r     <= id_nxt;
    owner_r  <= owner_nxt;
    period_r <= period_nxt;
    now_r    <= now_nxt;
    dl_r     <= dl_nxt;
    idx_r    <= idx_nxt;
    exp_r    <= exp_nxt;
    nact_r   <= nact_nxt;
    mark_r   <= mark_nxt;
    mper_r   <= mper_nxt;
    cur_r    <= cur_nxt;
    em_r     <= em_nxt;
    emf_r    <= emf_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    id_nxt     = id_r;
    owner_nxt  = owner_r;
    period_nxt = period_r;
    now_nxt    = now_r;
    dl_nxt     = dl_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    exp_nxt    = exp_r;
    nact_nxt   = nact_r;
    mv_nxt     = mv_r;
    mark_nxt   = mark_r;
    mper_nxt   = mper_r;
    cur_nxt    = cur_r;
    em_nxt     = em_r;
    emf_nxt    = emf_r;
    ins_done   = 1'b0;
    rm_done    = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = idx_r[AW-1:0];
    mem_wdata  = {id_r, owner_r, period_r, dl_r};
    mem_raddr  = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_req_type;
          id_nxt     = in_timer_id;
          owner_nxt  = in_owner_tag;
          period_nxt = PER_W'(in_interval_ms) * PER_W'(MS_TO_US);
          now_nxt    = in_now_us;
          emf_nxt    = 1'b0;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_EMIT;
        em_nxt    = '{status: ST_OK, fired: 1'b0, fired_count: '0,
                      wait_valid: 1'b0, wait_us: '0, last: 1'b1};
        case (req_r)
          REQ_REGISTER: begin
            if (cnt_r == CNT_FULL) begin
              em_nxt.status = ST_FULL;
            end else begin
              dl_nxt    = sat_add(now_r, TW'(period_r));
              idx_nxt   = cnt_r;
              state_nxt = S_INS_RD;
            end
          end
          REQ_REMOVE_ID: begin
            exp_nxt   = '0;
            state_nxt = S_SCAN_RD;
          end
          REQ_REMOVE_OW: begin
            if (cnt_r == '0) begin
              em_nxt.status = ST_NOTFOUND;
            end else begin
              exp_nxt   = '0;
              state_nxt = S_OWN_RD;
            end
          end
          REQ_WAIT: begin
            if (cnt_r == '0) begin
              em_nxt.status = ST_NOTFOUND;
            end else begin
              state_nxt = S_WAIT;
            end
          end
          REQ_ACTIVATE: begin
            if (cnt_r == '0) begin
              em_nxt.status = ST_NOTFOUND;
            end else begin
              exp_nxt   = '0;
              nact_nxt  = '0;
              mv_nxt    = 1'b0;
              state_nxt = S_EXP_RD;
            end
          end
          default: begin
            em_nxt.status = ST_OK;
          end
        endcase
      end
      S_INS_RD: begin
        if (idx_r == '0) begin
          mem_we   = 1'b1;
          ins_done = 1'b1;
        end else begin
          mem_raddr = AW'(idx_r - 1'b1);
          state_nxt = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        mem_we = 1'b1;
        if (dl_r < rd_dl) begin
          mem_wdata = mem_rdata;
          idx_nxt   = idx_r - 1'b1;
          state_nxt = S_INS_RD;
        end else begin
          ins_done = 1'b1;
        end
      end
      S_RM_RD: begin
        if ((idx_r + 1'b1) < cnt_r) begin
          mem_raddr = AW'(idx_r + 1'b1);
          state_nxt = S_RM_WR;
        end else begin
          rm_done = 1'b1;
        end
      end
      S_RM_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_RM_RD;
      end
      S_SCAN_RD: begin
        if (exp_r < cnt_r) begin
          mem_raddr = exp_r[AW-1:0];
          state_nxt = S_SCAN_CHK;
        end else begin
          em_nxt    = '{status: ST_NOTFOUND, fired: 1'b0, fired_count: '0,
                        wait_valid: 1'b0, wait_us: '0, last: 1'b1};
          state_nxt = S_EMIT;
        end
      end
      S_SCAN_CHK: begin
        if (rd_id == id_r) begin
          idx_nxt   = exp_r;
          state_nxt = S_RM_RD;
        end else begin
          exp_nxt   = exp_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_OWN_RD: begin
        if (exp_r < cnt_r) begin
          mem_raddr = exp_r[AW-1:0];
          state_nxt = S_OWN_CHK;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_OWN_CHK: begin
        if (rd_owner == owner_r) begin
          idx_nxt   = exp_r;
          state_nxt = S_RM_RD;
        end else begin
          exp_nxt   = exp_r + 1'b1;
          state_nxt = S_OWN_RD;
        end
      end
      S_WAIT: begin
        em_nxt.wait_valid = 1'b1;
        em_nxt.wait_us    = (now_r < rd_dl) ? (rd_dl - now_r) : '0;
        state_nxt         = S_EMIT;
      end
      S_EXP_RD: begin
        if (exp_r < cnt_r) begin
          mem_raddr = exp_r[AW-1:0];
          state_nxt = S_EXP_CHK;
        end else begin
          state_nxt = S_ACT_HEAD;
        end
      end
      S_EXP_CHK: begin
        if (!(now_r < rd_dl)) begin
          exp_nxt   = exp_r + 1'b1;
          state_nxt = S_EXP_RD;
        end else begin
          state_nxt = S_ACT_HEAD;
        end
      end
      S_ACT_HEAD: begin
        em_nxt = '{status: ST_OK, fired: 1'b0, fired_count: nact_r,
                   wait_valid: 1'b0, wait_us: '0, last: 1'b1};
        emf_nxt = 1'b0;
        if (exp_r == '0) begin
          state_nxt = S_EMIT;
        end else begin
          exp_nxt   = exp_r - 1'b1;
          state_nxt = S_ACT_CHK;
        end
      end
      S_ACT_CHK: begin
        if ((now_r < rd_dl) || (mv_r && (mark_r == '0))) begin
          state_nxt = S_EMIT;
        end else begin
          cur_nxt    = !mv_r || (rd_per <= mper_r);
          if (mv_r && !(rd_per <= mper_r)) begin
            mark_nxt = mark_r - 1'b1;
          end
          id_nxt     = rd_id;
          owner_nxt  = rd_owner;
          period_nxt = rd_per;
          dl_nxt     = sat_add(rd_dl, TW'(rd_per));
          idx_nxt    = '0;
          state_nxt  = S_RM_RD;
        end
      end
      S_EMIT: begin
        if (emit_ack) begin
          state_nxt = em_r.last ? S_IDLE : S_ACT_HEAD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (rm_done) begin
      cnt_nxt = cnt_r - 1'b1;
      case (req_r)
        REQ_REMOVE_OW: begin
          state_nxt = S_OWN_RD;
        end
        REQ_ACTIVATE: begin
          if (dl_r < now_r) begin
            dl_nxt = sat_add(now_r, TW'(period_r));
          end
          idx_nxt   = cnt_r - 1'b1;
          state_nxt = S_INS_RD;
        end
        default: begin
          em_nxt    = '{status: ST_OK, fired: 1'b0, fired_count: '0,
                        wait_valid: 1'b0, wait_us: '0, last: 1'b1};
          state_nxt = S_EMIT;
        end
      endcase
    end

    if (ins_done) begin
      cnt_nxt   = cnt_r + 1'b1;
      state_nxt = S_EMIT;
      if (req_r == REQ_ACTIVATE) begin
        if (cur_r) begin
          mv_nxt   = 1'b1;
          mark_nxt = idx_r[AW-1:0];
          mper_nxt = period_r;
        end else if (CW'(mark_r) >= idx_r) begin
          mark_nxt = mark_r + 1'b1;
        end
        if ((period_r != '0) && (nact_r != FCNT_MAX)) begin
          nact_nxt = nact_r + 1'b1;
        end
        em_nxt  = '{status: ST_OK, fired: 1'b1, fired_count: '0,
                    wait_valid: 1'b0, wait_us: '0, last: 1'b0};
        emf_nxt = 1'b1;
      end else begin
        em_nxt  = '{status: ST_OK, fired: 1'b0, fired_count: '0,
                    wait_valid: 1'b0, wait_us: '0, last: 1'b1};
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("entry count above table size");

  a_mark_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACT_HEAD && mv_r) |-> (CW'(mark_r) < cnt_r))
    else $error("guard entry outside table");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && emit_ack && em_r.last) |=> (state_r == S_IDLE))
    else $error("sequencer busy after final item");

  a_fired_id: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && !em_r.fired) |-> (emit_id == '0))
    else $error("fired id on non-fired item");

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// tb_top: self-checking testbench of periodic_timer_queue_core
// drives requests with random bursts and gaps, predicts results from its own timer table
// depends on ptq_pkg and periodic_timer_queue_core
`default_nettype none
module tb_top;
  import ptq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 16;

  typedef struct {
    logic [1:0]        status;
    logic [15:0]       fired_id;
    logic              fired;
    logic [FCNT_W-1:0] fired_count;
    logic              wait_valid;
    logic [TW-1:0]     wait_us;
    logic              last;
  } answer_t;

  int mismatches = 0;
  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  class timer_scoreboard;
    logic [15:0]   tid[DEPTH];
    logic [7:0]    town[DEPTH];
    logic [35:0]   tper[DEPTH];
    logic [TW-1:0] tdl[DEPTH];
    int            used;
    answer_t       pending[$];

    function void push_answer(logic [1:0] st, logic [15:0] fid, logic fd, logic [4:0] fc,
                              logic wv, logic [TW-1:0] wu, logic lst);
      answer_t a;
      a.status = st; a.fired_id = fid; a.fired = fd; a.fired_count = fc;
      a.wait_valid = wv; a.wait_us = wu; a.last = lst;
      pending.push_back(a);
    endfunction

    function logic [TW-1:0] add_sat(logic [TW-1:0] a, logic [35:0] b);
      logic [TW:0] s;
      s = {1'b0, a} + b;
      return s[TW] ? T_MAX : s[TW-1:0];
    endfunction

    function void drop(int p);
      for (int i = p; i + 1 < used; i++) begin
        tid[i] = tid[i+1]; town[i] = town[i+1]; tper[i] = tper[i+1]; tdl[i] = tdl[i+1];
      end
      used--;
    endfunction

    function int place(logic [15:0] id, logic [7:0] ow, logic [35:0] per, logic [TW-1:0] dl);
      int p;
      p = used;
      while (p > 0 && dl < tdl[p-1]) p--;
      for (int i = used; i > p; i--) begin
        tid[i] = tid[i-1]; town[i] = town[i-1]; tper[i] = tper[i-1]; tdl[i] = tdl[i-1];
      end
      tid[p] = id; town[p] = ow; tper[p] = per; tdl[p] = dl;
      used++;
      return p;
    endfunction

    function void note_request(logic [2:0] rq, logic [15:0] id, logic [7:0] ow,
                               logic [23:0] ivl, logic [TW-1:0] now);
      logic [35:0] per;
      int i, expired, nact, mark, p;
      logic cur;
      logic [15:0] fid;
      logic [7:0] fow;
      logic [35:0] fper;
      logic [TW-1:0] fdl;
      per = ivl * 36'd1000;
      case (rq)
        REQ_REGISTER: begin
          if (used >= DEPTH) push_answer(ST_FULL, 0, 0, 0, 0, 0, 1);
          else begin
            void'(place(id, ow, per, add_sat(now, per)));
            push_answer(ST_OK, 0, 0, 0, 0, 0, 1);
          end
        end
        REQ_REMOVE_ID: begin
          p = -1;
          for (i = 0; i < used; i++) if (p < 0 && tid[i] == id) p = i;
          if (p >= 0) begin
            drop(p);
            push_answer(ST_OK, 0, 0, 0, 0, 0, 1);
          end else push_answer(ST_NOTFOUND, 0, 0, 0, 0, 0, 1);
        end
        REQ_REMOVE_OW: begin
          if (used == 0) push_answer(ST_NOTFOUND, 0, 0, 0, 0, 0, 1);
          else begin
            i = 0;
            while (i < used) if (town[i] == ow) drop(i); else i++;
            push_answer(ST_OK, 0, 0, 0, 0, 0, 1);
          end
        end
        REQ_WAIT: begin
          if (used == 0) push_answer(ST_NOTFOUND, 0, 0, 0, 0, 0, 1);
          else push_answer(ST_OK, 0, 0, 0, 1, (now < tdl[0]) ? tdl[0] - now : '0, 1);
        end
        REQ_ACTIVATE: begin
          if (used == 0) push_answer(ST_NOTFOUND, 0, 0, 0, 0, 0, 1);
          else begin
            expired = 0; nact = 0; mark = -1;
            while (expired < used && !(now < tdl[expired])) expired++;
            while (expired > 0) begin
              expired--;
              if (used == 0 || now < tdl[0]) break;
              cur = 0;
              if (mark < 0) cur = 1;
              else if (mark == 0) break;
              else if (tper[0] <= tper[mark]) cur = 1;
              fid = tid[0]; fow = town[0]; fper = tper[0]; fdl = tdl[0];
              drop(0);
              if (!cur) mark--;
              fdl = add_sat(fdl, fper);
              if (fdl < now) fdl = add_sat(now, fper);
              p = place(fid, fow, fper, fdl);
              if (cur) mark = p;
              else if (mark >= p) mark++;
              if (fper != 0 && nact < 31) nact++;
              push_answer(ST_OK, fid, 1, 0, 0, 0, 0);
            end
            push_answer(ST_OK, 0, 0, nact[4:0], 0, 0, 1);
          end
        end
        default: push_answer(ST_OK, 0, 0, 0, 0, 0, 1);
      endcase
    endfunction

    task check_result(answer_t got);
      answer_t w;
      if (pending.size() == 0) begin
        report_mismatch("result item with nothing pending");
        return;
      end
      w = pending.pop_front();
      if (got.status !== w.status)
        report_mismatch($sformatf("status %0d exp %0d", got.status, w.status));
      if (got.fired_id !== w.fired_id)
        report_mismatch($sformatf("fired_id %0d exp %0d", got.fired_id, w.fired_id));
      if (got.fired !== w.fired)
        report_mismatch($sformatf("fired %0d exp %0d", got.fired, w.fired));
      if (got.fired_count !== w.fired_count)
        report_mismatch($sformatf("fired_count %0d exp %0d", got.fired_count, w.fired_count));
      if (got.wait_valid !== w.wait_valid)
        report_mismatch($sformatf("wait_valid %0d exp %0d", got.wait_valid, w.wait_valid));
      if (got.wait_us !== w.wait_us)
        report_mismatch($sformatf("wait_us %0d exp %0d", got.wait_us, w.wait_us));
      if (got.last !== w.last)
        report_mismatch($sformatf("last %0d exp %0d", got.last, w.last));
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [2:0] in_req_type = 0;
  logic [15:0] in_timer_id = 0;
  logic [7:0] in_owner_tag = 0;
  logic [IVL_W-1:0] in_interval_ms = 0;
  logic [TW-1:0] in_now_us = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [1:0] out_status;
  logic [15:0] out_fired_id;
  logic out_fired;
  logic [FCNT_W-1:0] out_fired_count;
  logic out_wait_valid;
  logic [TW-1:0] out_wait_us;
  logic out_last;

  always #5 clk = ~clk;

  periodic_timer_queue_core i_dut (.*);

  timer_scoreboard sb = new();
  logic [TW-1:0] clock_us = 0;
  bit hold_off = 0;
  bit hold_go = 0;
  bit stim_done = 0;

  task automatic send_request(logic [2:0] rq, logic [15:0] id, logic [7:0] ow,
                              logic [23:0] ivl, logic [TW-1:0] now);
    in_valid <= 1; in_req_type <= rq; in_timer_id <= id; in_owner_tag <= ow;
    in_interval_ms <= ivl; in_now_us <= now;
    do @(posedge clk); while (in_stall);
    sb.note_request(rq, id, ow, ivl, now);
  endtask

  task automatic pause_sender();
    int g;
    in_valid <= 0;
    g = $urandom_range(1, 12);
    repeat (g) @(posedge clk);
  endtask

  task automatic random_request();
    logic [2:0] rq;
    logic [15:0] id;
    int r;
    r = $urandom_range(0, 99);
    clock_us = clock_us + $urandom_range(0, 3000);
    id = 16'($urandom_range(0, 11));
    if ($urandom_range(0, 9) == 0) id = 16'($urandom);
    if (r < 40) rq = REQ_REGISTER;
    else if (r < 52) rq = REQ_REMOVE_ID;
    else if (r < 58) rq = REQ_REMOVE_OW;
    else if (r < 68) rq = REQ_WAIT;
    else if (r < 97) rq = REQ_ACTIVATE;
    else rq = 3'($urandom_range(5, 7));
    send_request(rq, id, ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3)),
                 ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 4)),
                 ($urandom_range(0, 30) == 0) ? TW'({$urandom, $urandom}) : clock_us);
  endtask

  initial begin
    int burst;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // empty table cases
    send_request(REQ_WAIT, 0, 0, 0, 0);
    send_request(REQ_ACTIVATE, 0, 0, 0, 0);
    send_request(REQ_REMOVE_OW, 0, 0, 0, 0);
    send_request(REQ_REMOVE_ID, 16'hffff, 0, 0, 0);
    // fill to full, id zero, duplicates, extremes
    for (int i = 0; i < 16; i++)
      send_request(REQ_REGISTER, (i == 3) ? 16'd0 : 16'(i % 12), 8'(i == 5 ? 8'hff : i % 3),
                   (i == 7) ? 24'hffffff : 24'(i % 3), (i == 9) ? T_MAX : TW'(i * 10));
    send_request(REQ_REGISTER, 16'hffff, 8'hff, 24'hffffff, T_MAX);
    send_request(REQ_WAIT, 0, 0, 0, 5);
    send_request(REQ_ACTIVATE, 0, 0, 0, T_MAX);
    send_request(3'd7, 16'hffff, 8'hff, 24'hffffff, T_MAX);
    send_request(REQ_REMOVE_ID, 16'd0, 0, 0, 0);
    send_request(REQ_REMOVE_OW, 0, 8'hff, 0, 0);
    send_request(REQ_REMOVE_OW, 0, 8'd1, 0, 0);
    for (int n = 0; n < 300; n++) begin
      if (n == 150) hold_go = 1;
      random_request();
      if ($urandom_range(0, 3) == 0) begin
        burst = $urandom_range(0, 2);
        if (burst != 0) pause_sender();
      end
    end
    in_valid <= 0;
    stim_done = 1;
  end

  // long receiver hold-off so the output register stays full and the block stalls its input
  initial begin
    wait (hold_go);
    hold_off = 1;
    repeat (400) @(posedge clk);
    hold_off = 0;
  end

  always @(posedge clk) begin
    if (hold_off) out_stall <= 1;
    else if ($urandom_range(0, 63) < 8) out_stall <= 1;
    else if (($urandom_range(0, 255) & 8'h30) != 0) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= 0;
  end

  always @(posedge clk) begin
    answer_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.status = out_status; got.fired_id = out_fired_id; got.fired = out_fired;
      got.fired_count = out_fired_count; got.wait_valid = out_wait_valid;
      got.wait_us = out_wait_us; got.last = out_last;
      sb.check_result(got);
    end
  end

  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && sb.pending.size() == 0)
      $display("periodic_timer_queue_core verification clean");
    else $display("periodic_timer_queue_core verification failed");
    $finish;
  end

  initial begin
    #50ms;
    $display("periodic_timer_queue_core verification failed");
    $finish;
  end
endmodule
`default_nettype wire
